@@ design/crp_pkg.sv @@
// Shared widths and data types for the complex reciprocal pipeline.
`timescale 1ns / 1ps

package crp_pkg;

   localparam int InWidth   = 16;
   localparam int MagWidth  = InWidth + 1;
   localparam int SqWidth   = 2 * InWidth - 1;
   localparam int NormWidth = 2 * InWidth;
   localparam int DivWidth  = NormWidth + 1;
   localparam int QuoWidth  = NormWidth - 1;
   localparam int OutWidth  = 32;

   typedef struct packed {
      logic [DivWidth-1:0] rem_re;
      logic [DivWidth-1:0] rem_im;
      logic [DivWidth-1:0] divisor;
      logic [QuoWidth-1:0] low_bits;
      logic [QuoWidth-1:0] quo_re;
      logic [QuoWidth-1:0] quo_im;
      logic                neg_re;
      logic                neg_im;
      logic                zero;
      logic                last;
   } cell_data_type;

   typedef struct packed {
      logic signed [OutWidth-1:0] recip_real;
      logic signed [OutWidth-1:0] recip_imag;
      logic                       zero_input;
      logic                       last_out;
   } result_type;

endpackage

@@ design/complex_reciprocal.sv @@
// Top level of the complex reciprocal: front stages, divider cell chain, output skid.
`timescale 1ns / 1ps

// Returns (a - jb) / (a*a + b*b) for each 16-bit signed sample as two Q2.30 parts,
// rounded to nearest with ties away from zero; a zero sample gives zero parts and
// raises rsp_zero_input. One item is accepted every cycle while req_stall is low.
// Each result passes the front registers for magnitudes, squares and norm, the chain
// of divider cells that resolve one quotient bit each, and the sign and output stage.
// An output register with a skid stage keeps req_stall low while a single result
// waits at the output.

module complex_reciprocal (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [crp_pkg::InWidth-1:0]  req_real_part,
   input  logic signed [crp_pkg::InWidth-1:0]  req_imag_part,
   input  logic                                req_last_item,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [crp_pkg::OutWidth-1:0] rsp_recip_real,
   output logic signed [crp_pkg::OutWidth-1:0] rsp_recip_imag,
   output logic                                rsp_zero_input,
   output logic                                rsp_last_out
);
   import crp_pkg::*;

   logic          adv, push, out_free;
   logic          chain_valid [QuoWidth+1];
   cell_data_type chain_data  [QuoWidth+1];
   cell_data_type tail;
   result_type    result, out_ff, skid_ff;
   logic          out_valid_ff, skid_valid_ff;
   logic [OutWidth-1:0] mag_re, mag_im;

   assign adv       = ~skid_valid_ff;
   assign req_stall = skid_valid_ff;

   crp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_real   (req_real_part),
      .in_imag   (req_imag_part),
      .in_last   (req_last_item),
      .out_valid (chain_valid[0]),
      .out_data  (chain_data[0])
   );

   for (genvar i = 0; i < QuoWidth; i++) begin : g_cell
      crp_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (chain_valid[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   assign tail   = chain_data[QuoWidth];
   assign mag_re = OutWidth'(tail.quo_re);
   assign mag_im = OutWidth'(tail.quo_im);

   always_comb begin
      result.recip_real = tail.neg_re ? (OutWidth'(0) - mag_re) : mag_re;
      result.recip_imag = tail.neg_im ? (OutWidth'(0) - mag_im) : mag_im;
      result.zero_input = tail.zero;
      result.last_out   = tail.last;
      if (tail.zero) begin
         result.recip_real = '0;
         result.recip_imag = '0;
      end
   end

   assign push     = adv & chain_valid[QuoWidth];
   assign out_free = ~out_valid_ff | ~rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff  <= skid_valid_ff | push;
         skid_valid_ff <= 1'b0;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_ff <= skid_valid_ff ? skid_ff : result;
      end else if (push) begin
         skid_ff <= result;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_recip_real = out_ff.recip_real;
   assign rsp_recip_imag = out_ff.recip_imag;
   assign rsp_zero_input = out_ff.zero_input;
   assign rsp_last_out   = out_ff.last_out;

endmodule

@@ design/crp_front.sv @@
// Front stages: magnitudes, squares and norm, forming the divider's first operands.
`timescale 1ns / 1ps

module crp_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic signed [crp_pkg::InWidth-1:0] in_real,
   input  logic signed [crp_pkg::InWidth-1:0] in_imag,
   input  logic                          in_last,
   output logic                          out_valid,
   output crp_pkg::cell_data_type        out_data
);
   import crp_pkg::*;

   logic                v1_ff, v2_ff, v3_ff;
   logic [MagWidth-1:0] mag_a1_ff, mag_b1_ff, mag_a2_ff, mag_b2_ff;
   logic                neg_a1_ff, neg_b1_ff, neg_a2_ff, neg_b2_ff;
   logic                last1_ff, last2_ff;
   logic [SqWidth-1:0]  sq_a2_ff, sq_b2_ff;
   logic [MagWidth-1:0] ext_a, ext_b;
   logic [SqWidth-1:0]  prod_a, prod_b;
   logic [NormWidth-1:0] norm;
   cell_data_type       data_in, data_ff;

   assign ext_a  = {in_real[InWidth-1], in_real};
   assign ext_b  = {in_imag[InWidth-1], in_imag};
   assign prod_a = SqWidth'(mag_a1_ff) * SqWidth'(mag_a1_ff);
   assign prod_b = SqWidth'(mag_b1_ff) * SqWidth'(mag_b1_ff);
   assign norm   = NormWidth'(sq_a2_ff) + NormWidth'(sq_b2_ff);

   always_comb begin
      data_in.rem_re   = DivWidth'(mag_a2_ff) + DivWidth'(norm[NormWidth-1]);
      data_in.rem_im   = DivWidth'(mag_b2_ff) + DivWidth'(norm[NormWidth-1]);
      data_in.divisor  = {norm, 1'b0};
      data_in.low_bits = norm[QuoWidth-1:0];
      data_in.quo_re   = '0;
      data_in.quo_im   = '0;
      data_in.neg_re   = neg_a2_ff;
      data_in.neg_im   = ~neg_b2_ff;
      data_in.zero     = (norm == '0);
      data_in.last     = last2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         neg_a1_ff <= in_real[InWidth-1];
         neg_b1_ff <= in_imag[InWidth-1];
         mag_a1_ff <= in_real[InWidth-1] ? (MagWidth'(0) - ext_a) : ext_a;
         mag_b1_ff <= in_imag[InWidth-1] ? (MagWidth'(0) - ext_b) : ext_b;
         last1_ff  <= in_last;
         mag_a2_ff <= mag_a1_ff;
         mag_b2_ff <= mag_b1_ff;
         neg_a2_ff <= neg_a1_ff;
         neg_b2_ff <= neg_b1_ff;
         last2_ff  <= last1_ff;
         sq_a2_ff  <= prod_a;
         sq_b2_ff  <= prod_b;
         data_ff   <= data_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = data_ff;

endmodule

@@ design/crp_cell.sv @@
// Divider cell: one quotient bit for both parts, then hand off to the next cell.
`timescale 1ns / 1ps

module crp_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  crp_pkg::cell_data_type in_data,
   output logic                   out_valid,
   output crp_pkg::cell_data_type out_data
);
   import crp_pkg::*;

   logic                valid_ff;
   cell_data_type       data_in, data_ff;
   logic [DivWidth:0]   shift_re, shift_im, trial_re, trial_im;
   logic                bit_in;

   assign bit_in   = in_data.low_bits[QuoWidth-1];
   assign shift_re = {in_data.rem_re, bit_in};
   assign shift_im = {in_data.rem_im, bit_in};
   assign trial_re = shift_re - {1'b0, in_data.divisor};
   assign trial_im = shift_im - {1'b0, in_data.divisor};

   always_comb begin
      data_in          = in_data;
      data_in.low_bits = {in_data.low_bits[QuoWidth-2:0], 1'b0};
      data_in.rem_re   = trial_re[DivWidth] ? shift_re[DivWidth-1:0] : trial_re[DivWidth-1:0];
      data_in.rem_im   = trial_im[DivWidth] ? shift_im[DivWidth-1:0] : trial_im[DivWidth-1:0];
      data_in.quo_re   = {in_data.quo_re[QuoWidth-2:0], ~trial_re[DivWidth]};
      data_in.quo_im   = {in_data.quo_im[QuoWidth-2:0], ~trial_im[DivWidth]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
